FILE: rtl/assert_macros.svh
// Assertion macros used by the timer scheduler core.
// Every macro expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rrts_pkg.sv
// Package for the relative repeat timer scheduler.
// Holds field widths, register indexes, status codes and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

   // Field widths fixed by the interface.
   localparam int FIELD_TIME_W = 40;
   localparam int PERIOD_W     = 31;
   localparam int RUNS_W       = 40;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 40;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_START_KIND    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LIFE_BEGIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LIFE_END      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FIRST_DELAY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RUN_LIMIT     = 3'd5;

   // Start kinds; only the timer start kind is served.
   localparam logic [1:0] KIND_SYSTEM_BOOT = 2'd0;
   localparam logic [1:0] KIND_TIMER_START = 2'd1;
   localparam logic [1:0] KIND_APP_START   = 2'd2;

   // Request beat modes.
   localparam logic MODE_QUERY = 1'b0;
   localparam logic MODE_FIRED = 1'b1;

   // Status codes returned with every result beat.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_OVERDUE      = 3'd1,
      ST_WAIT_REBOOT  = 3'd2,
      ST_WAIT_RESTART = 3'd3,
      ST_NO_CHANCE    = 3'd4,
      ST_BAD_TIMER    = 3'd5
   } status_type;

   // Which result the datapath forms when it loads the output register.
   typedef enum logic [2:0] {
      RES_OVERDUE_EARLY,
      RES_BAD_TIMER,
      RES_FIRST_RUN,
      RES_NO_CHANCE,
      RES_OVERDUE_LATE,
      RES_NEXT_RUN,
      RES_FIRED
   } result_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;
      logic            calc_first;
      logic            div_start;
      logic            div_step;
      logic            count;
      logic            add_period;
      logic            bump;
      logic            load_out;
      result_kind_type kind;
   } rrts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic overdue;
      logic kind_bad;
      logic first_ahead;
      logic no_repeat;
      logic div_last;
      logic limit_hit;
      logic base_late;
      logic out_free;
   } rrts_sts_type;

endpackage

`default_nettype wire

FILE: rtl/rrts_if.sv
// Valid/ready channel interfaces for the timer scheduler request and response beats.
// Depends on rrts_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rrts_req_if import rrts_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic [FIELD_TIME_W-1:0] test_time;

   modport source (output valid, output mode, output test_time, input ready);
   modport sink   (input valid, input mode, input test_time, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [FIELD_TIME_W-1:0] next_run_time;
   logic [PERIOD_W-1:0]     period_out;
   logic                    stop_now;

   modport source (output valid, output status, output next_run_time,
                   output period_out, output stop_now, input ready);
   modport sink   (input valid, input status, input next_run_time,
                   input period_out, input stop_now, output ready);
endinterface

`default_nettype wire

FILE: rtl/relative_repeat_timer_scheduler_core.sv
// Top level of the relative repeat timer scheduler: controller plus datapath.
// Depends on rrts_pkg, rrts_if, rrts_ctrl, rrts_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The block takes one beat at a time. A query beat that runs the divide passes
// through the states FIRST, CHECK, DIV, COUNT, LIMIT, LATE and REPLY, skipping LATE
// when the run count reaches the run limit; most of its time is spent in DIV, the
// radix-2 restoring divider that yields one quotient bit per cycle. A query settled
// before the divide (overdue, bad timer, first run ahead, no repeat) goes from CHECK
// straight to REPLY, and a fired beat passes through FIRE to REPLY. A response still
// waiting in the output register holds the next one back until the sink takes it.
// Once a response is loaded the next request is taken at once, even while the sink
// stalls. Configuration writes are taken in any cycle and must be made only while
// the block is idle.
module relative_repeat_timer_scheduler_core import rrts_pkg::*; #(
   parameter int TIME_BITS = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   rrts_req_if.sink                    req_ch,
   rrts_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   rrts_cmd_type cmd;
   rrts_sts_type sts;

   // Sequencer.
   rrts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_mode  (req_ch.mode),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Arithmetic, state and output register.
   rrts_datapath #(
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_test_time     (req_ch.test_time),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_next_run_time (rsp_ch.next_run_time),
      .rsp_period_out    (rsp_ch.period_out),
      .rsp_stop_now      (rsp_ch.stop_now)
   );

   // A response is only loaded into a free output slot.
   `ASSERT_IMPLY(a_load_free, cmd.load_out, sts.out_free, "response loaded into a busy slot")

   // No new request is taken while a response is being loaded.
   `ASSERT_IMPLY(a_load_not_ready, cmd.load_out, !req_ch.ready, "request taken during load")

   // The divider is never started with a zero period.
   `ASSERT_IMPLY(a_div_nonzero, cmd.div_start, !sts.no_repeat, "divide by zero period")

   // An accepted beat never produces its response in the very next cycle.
   `ASSERT_NEXT(a_no_instant, req_ch.valid && req_ch.ready, !cmd.load_out,
                "response loaded too early")

endmodule

`default_nettype wire

FILE: rtl/rrts_ctrl.sv
// Controller state machine of the timer scheduler.
// Sequences one beat at a time through the datapath; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_ctrl import rrts_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_mode,
   output logic              req_ready,
   output rrts_cmd_type      cmd,
   input  wire rrts_sts_type sts
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIRST,
      S_CHECK,
      S_DIV,
      S_COUNT,
      S_LIMIT,
      S_LATE,
      S_FIRE,
      S_REPLY
   } state_type;

   state_type       state_ff, state_in;
   result_kind_type kind_ff, kind_in;

   // Next state and the result to be loaded when the reply is sent.
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_mode == MODE_FIRED) ? S_FIRE : S_FIRST;
            end
         end
         S_FIRST: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_REPLY;
            if (sts.overdue) begin
               kind_in = RES_OVERDUE_EARLY;
            end else if (sts.kind_bad) begin
               kind_in = RES_BAD_TIMER;
            end else if (sts.first_ahead) begin
               kind_in = RES_FIRST_RUN;
            end else if (sts.no_repeat) begin
               kind_in = RES_NO_CHANCE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_last) begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            state_in = S_LIMIT;
         end
         S_LIMIT: begin
            if (sts.limit_hit) begin
               state_in = S_REPLY;
               kind_in  = RES_NO_CHANCE;
            end else begin
               state_in = S_LATE;
            end
         end
         S_LATE: begin
            state_in = S_REPLY;
            kind_in  = sts.base_late ? RES_OVERDUE_LATE : RES_NEXT_RUN;
         end
         S_FIRE: begin
            state_in = S_REPLY;
            kind_in  = RES_FIRED;
         end
         S_REPLY: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and the registered result kind.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         kind_ff  <= RES_FIRED;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd            = '0;
      cmd.kind       = kind_ff;
      cmd.capture    = (state_ff == S_IDLE) && req_valid;
      cmd.calc_first = (state_ff == S_FIRST);
      cmd.div_start  = (state_ff == S_CHECK) && !sts.overdue && !sts.kind_bad
                       && !sts.first_ahead && !sts.no_repeat;
      cmd.div_step   = (state_ff == S_DIV);
      cmd.count      = (state_ff == S_COUNT);
      cmd.add_period = (state_ff == S_LIMIT);
      cmd.bump       = (state_ff == S_FIRE);
      cmd.load_out   = (state_ff == S_REPLY) && sts.out_free;
   end

   // No beat is taken while reset is held.
   assign req_ready = (state_ff == S_IDLE) && !reset;

endmodule

`default_nettype wire

FILE: rtl/rrts_datapath.sv
// Datapath of the timer scheduler: configuration, run count, divider and output register.
// Driven by rrts_ctrl through the command struct; depends on rrts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrts_datapath import rrts_pkg::*; #(
   parameter int TIME_BITS = 40
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [FIELD_TIME_W-1:0] req_test_time,
   input  wire rrts_cmd_type            cmd,
   output rrts_sts_type                 sts,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic [FIELD_TIME_W-1:0]      rsp_next_run_time,
   output logic [PERIOD_W-1:0]          rsp_period_out,
   output logic                         rsp_stop_now
);

   localparam int CntW = $clog2(TIME_BITS);

   // Configuration registers.
   logic [1:0]              start_kind_ff, start_kind_in;
   logic [FIELD_TIME_W-1:0] life_begin_ff, life_begin_in;
   logic [FIELD_TIME_W-1:0] life_end_ff, life_end_in;
   logic [PERIOD_W-1:0]     first_delay_ff, first_delay_in;
   logic [PERIOD_W-1:0]     repeat_period_ff, repeat_period_in;
   logic [PERIOD_W-1:0]     run_limit_ff, run_limit_in;

   // Working registers.
   logic [RUNS_W-1:0]    runs_done_ff, runs_done_in;
   logic [TIME_BITS-1:0] test_ff, test_in;
   logic [TIME_BITS-1:0] first_ff, first_in;
   logic [TIME_BITS-1:0] quot_ff, quot_in;
   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [TIME_BITS-1:0] base_ff, base_in;

   // Output register.
   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [FIELD_TIME_W-1:0] out_next_ff, out_next_in;
   logic [PERIOD_W-1:0]     out_period_ff, out_period_in;
   logic                    out_stop_ff, out_stop_in;

   logic [TIME_BITS-1:0] life_begin_w;
   logic [TIME_BITS-1:0] life_end_w;
   logic [PERIOD_W:0]    trial;
   logic [PERIOD_W:0]    divisor;
   logic                 trial_ge;
   logic [63:0]          quot_wide;
   logic                 limit_hit;

   // Sum that sticks at all ones of the time width.
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [PERIOD_W-1:0]  b);
      logic [TIME_BITS:0] s;
      s = (TIME_BITS+1)'(a) + (TIME_BITS+1)'(b);
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction

   assign life_begin_w = TIME_BITS'(life_begin_ff);
   assign life_end_w   = TIME_BITS'(life_end_ff);

   // Configuration writes.
   always_comb begin
      start_kind_in    = start_kind_ff;
      life_begin_in    = life_begin_ff;
      life_end_in      = life_end_ff;
      first_delay_in   = first_delay_ff;
      repeat_period_in = repeat_period_ff;
      run_limit_in     = run_limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_START_KIND:    start_kind_in    = csr_wdata[1:0];
            REG_LIFE_BEGIN:    life_begin_in    = csr_wdata[FIELD_TIME_W-1:0];
            REG_LIFE_END:      life_end_in      = csr_wdata[FIELD_TIME_W-1:0];
            REG_FIRST_DELAY:   first_delay_in   = csr_wdata[PERIOD_W-1:0];
            REG_REPEAT_PERIOD: repeat_period_in = csr_wdata[PERIOD_W-1:0];
            REG_RUN_LIMIT:     run_limit_in     = csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // One restoring divide step: shift in the next dividend bit and try the subtraction.
   assign divisor  = {1'b0, repeat_period_ff};
   assign trial    = {rem_ff, quot_ff[TIME_BITS-1]};
   assign trial_ge = (trial >= divisor);

   // Quotient widened so that it can be clipped to the run counter.
   assign quot_wide = 64'(quot_ff);
   assign limit_hit = (run_limit_ff != '0) && (runs_done_ff >= RUNS_W'(run_limit_ff));

   // Working register updates.
   always_comb begin
      test_in      = test_ff;
      first_in     = first_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      base_in      = base_ff;
      runs_done_in = runs_done_ff;
      if (cmd.capture) begin
         test_in = TIME_BITS'(req_test_time);
      end
      if (cmd.calc_first) begin
         first_in = sat_add(life_begin_w, first_delay_ff);
      end
      if (cmd.div_start) begin
         quot_in = test_ff - first_ff;
         rem_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.div_step) begin
         quot_in = {quot_ff[TIME_BITS-2:0], trial_ge};
         rem_in  = trial_ge ? PERIOD_W'(trial - divisor) : trial[PERIOD_W-1:0];
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.count) begin
         runs_done_in = (quot_wide[63:RUNS_W] != '0) ? '1 : quot_wide[RUNS_W-1:0];
         base_in      = test_ff - TIME_BITS'(rem_ff);
      end
      if (cmd.add_period) begin
         base_in = sat_add(base_ff, repeat_period_ff);
      end
      if (cmd.bump && (runs_done_ff != '1)) begin
         runs_done_in = runs_done_ff + 1'b1;
      end
   end

   // Status towards the controller.
   always_comb begin
      sts.overdue     = (test_ff >= life_end_w);
      sts.kind_bad    = (start_kind_ff != KIND_TIMER_START);
      sts.first_ahead = (first_ff > test_ff);
      sts.no_repeat   = (repeat_period_ff == '0);
      sts.div_last    = (cnt_ff == CntW'(TIME_BITS - 1));
      sts.limit_hit   = limit_hit;
      sts.base_late   = (base_ff >= life_end_w);
      sts.out_free    = !out_valid_ff || rsp_ready;
   end

   // Result formed from the registered kind when the controller loads the output.
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_next_in   = out_next_ff;
      out_period_in = out_period_ff;
      out_stop_in   = out_stop_ff;
      if (cmd.load_out) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_OK;
         out_next_in   = '0;
         out_period_in = repeat_period_ff;
         out_stop_in   = 1'b0;
         case (cmd.kind)
            RES_OVERDUE_EARLY: begin
               out_status_in = ST_OVERDUE;
               out_period_in = '0;
            end
            RES_BAD_TIMER: begin
               out_status_in = ST_BAD_TIMER;
               out_period_in = '0;
            end
            RES_FIRST_RUN: begin
               out_next_in = FIELD_TIME_W'(first_ff);
            end
            RES_NO_CHANCE: begin
               out_status_in = ST_NO_CHANCE;
            end
            RES_OVERDUE_LATE: begin
               out_status_in = ST_OVERDUE;
            end
            RES_NEXT_RUN: begin
               out_next_in = FIELD_TIME_W'(base_ff);
            end
            RES_FIRED: begin
               out_period_in = '0;
               out_stop_in   = limit_hit;
            end
            default: begin
            end
         endcase
      end
   end

   // Control and configuration registers take reset; payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_kind_ff    <= KIND_TIMER_START;
         life_begin_ff    <= '0;
         life_end_ff      <= '1;
         first_delay_ff   <= '0;
         repeat_period_ff <= '0;
         run_limit_ff     <= '0;
         runs_done_ff     <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         start_kind_ff    <= start_kind_in;
         life_begin_ff    <= life_begin_in;
         life_end_ff      <= life_end_in;
         first_delay_ff   <= first_delay_in;
         repeat_period_ff <= repeat_period_in;
         run_limit_ff     <= run_limit_in;
         runs_done_ff     <= runs_done_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      test_ff       <= test_in;
      first_ff      <= first_in;
      quot_ff       <= quot_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      out_status_ff <= out_status_in;
      out_next_ff   <= out_next_in;
      out_period_ff <= out_period_in;
      out_stop_ff   <= out_stop_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_next_run_time = out_next_ff;
   assign rsp_period_out    = out_period_ff;
   assign rsp_stop_now      = out_stop_ff;

endmodule

`default_nettype wire

FILE: test/tb_relative_repeat_timer_scheduler_core.sv
// Self-checking testbench for the relative repeat timer scheduler core.
// Uses rrts_pkg and the rrts_req_if / rrts_rsp_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb_relative_repeat_timer_scheduler_core;
   import rrts_pkg::*;

   localparam int TW = FIELD_TIME_W;
   localparam logic [TW-1:0]       TIME_MAX   = '1;
   localparam logic [RUNS_W-1:0]   RUNS_MAX   = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
   localparam logic [1:0]          KIND_RESERVED = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int PHASES         = 31;
   localparam int PHASE_ITEMS    = 50;

   typedef struct packed {
      logic          mode;
      logic [TW-1:0] test_time;
      logic          hold;
   } sched_item_type;

   typedef struct packed {
      status_type          status;
      logic [TW-1:0]       next_run_time;
      logic [PERIOD_W-1:0] period;
      logic                stop_now;
   } sched_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rrts_req_if req_bus ();
   rrts_rsp_if rsp_bus ();

   // Items waiting to be sent and schedule results still owed by the block.
   sched_item_type   pending_items[$];
   sched_result_type expected_results[$];

   // Local copy of the timer settings and of the run counter.
   logic [1:0]          cfg_start_kind    = KIND_TIMER_START;
   logic [TW-1:0]       cfg_life_begin    = '0;
   logic [TW-1:0]       cfg_life_end      = '1;
   logic [PERIOD_W-1:0] cfg_first_delay   = '0;
   logic [PERIOD_W-1:0] cfg_repeat_period = '0;
   logic [PERIOD_W-1:0] cfg_run_limit     = '0;
   logic [RUNS_W-1:0]   runs_count        = '0;

   int sender_idle_pct   = 33;
   int receiver_idle_pct = 73;
   int mismatch_count    = 0;
   int stall_cycles      = 0;

   relative_repeat_timer_scheduler_core #(.TIME_BITS(TW)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock, and known levels on every input from time zero.
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_START_KIND;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_QUERY;
      req_bus.test_time = '0;
      rsp_bus.ready     = 1'b0;
      forever #2 clock = ~clock;
   end

   // Time sums saturate at all ones of the time width.
   function automatic logic [63:0] time_sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      if (s > TIME_MAX)
         return TIME_MAX;
      return s;
   endfunction

   // Works out the result of one beat and updates the run counter.
   function automatic sched_result_type predict_schedule(input logic mode,
                                                         input logic [TW-1:0] test);
      sched_result_type r;
      logic [63:0]      first;
      logic [63:0]      elapsed;
      logic [63:0]      count;
      logic [63:0]      base;
      r.status        = ST_OK;
      r.next_run_time = '0;
      r.period        = '0;
      r.stop_now      = 1'b0;
      if (mode == MODE_FIRED) begin
         if (runs_count != RUNS_MAX)
            runs_count = runs_count + 1'b1;
         r.stop_now = (cfg_run_limit != 0) && (runs_count >= cfg_run_limit);
         return r;
      end
      // The life end check comes ahead of the start kind check.
      if (test >= cfg_life_end) begin
         r.status = ST_OVERDUE;
         return r;
      end
      if (cfg_start_kind != KIND_TIMER_START) begin
         r.status = ST_BAD_TIMER;
         return r;
      end
      r.period = cfg_repeat_period;
      first    = time_sat_add(cfg_life_begin, cfg_first_delay);
      // A first run still ahead is reported even when it lies past the life end.
      if (first > test) begin
         r.next_run_time = first[TW-1:0];
         return r;
      end
      if (cfg_repeat_period == 0) begin
         r.status = ST_NO_CHANCE;
         return r;
      end
      elapsed    = test - first;
      count      = elapsed / cfg_repeat_period;
      runs_count = (count > RUNS_MAX) ? RUNS_MAX : count[RUNS_W-1:0];
      if (cfg_run_limit != 0 && runs_count >= cfg_run_limit) begin
         r.status = ST_NO_CHANCE;
         return r;
      end
      base = time_sat_add(test - (elapsed % cfg_repeat_period), cfg_repeat_period);
      if (base >= cfg_life_end) begin
         r.status = ST_OVERDUE;
         return r;
      end
      r.next_run_time = base[TW-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Request driver: predicts each accepted beat and presents the next one.
   always @(posedge clock) begin : drive_requests
      sched_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_results.push_back(predict_schedule(req_bus.mode, req_bus.test_time));
         if (!req_bus.valid || req_bus.ready) begin
            // A held item waits until every owed result has arrived.
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
                !(pending_items[0].hold && expected_results.size() != 0)) begin
               item = pending_items.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.mode      <= item.mode;
               req_bus.test_time <= item.test_time;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks every accepted beat against the oldest expectation.
   always @(posedge clock) begin : check_responses
      sched_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response status", rsp_bus.status, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", rsp_bus.status, want.status);
               if (rsp_bus.next_run_time !== want.next_run_time)
                  report_mismatch("next_run_time", rsp_bus.next_run_time, want.next_run_time);
               if (rsp_bus.period_out !== want.period)
                  report_mismatch("period_out", rsp_bus.period_out, want.period);
               if (rsp_bus.stop_now !== want.stop_now)
                  report_mismatch("stop_now", rsp_bus.stop_now, want.stop_now);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_START_KIND:    cfg_start_kind    = data[1:0];
         REG_LIFE_BEGIN:    cfg_life_begin    = data[TW-1:0];
         REG_LIFE_END:      cfg_life_end      = data[TW-1:0];
         REG_FIRST_DELAY:   cfg_first_delay   = data[PERIOD_W-1:0];
         REG_REPEAT_PERIOD: cfg_repeat_period = data[PERIOD_W-1:0];
         REG_RUN_LIMIT:     cfg_run_limit     = data[PERIOD_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CSR_DATA_W-1:0] kind,
                                 input logic [CSR_DATA_W-1:0] life_begin,
                                 input logic [CSR_DATA_W-1:0] life_end,
                                 input logic [CSR_DATA_W-1:0] delay,
                                 input logic [CSR_DATA_W-1:0] period,
                                 input logic [CSR_DATA_W-1:0] limit);
      write_csr(REG_START_KIND, kind);
      write_csr(REG_LIFE_BEGIN, life_begin);
      write_csr(REG_LIFE_END, life_end);
      write_csr(REG_FIRST_DELAY, delay);
      write_csr(REG_REPEAT_PERIOD, period);
      write_csr(REG_RUN_LIMIT, limit);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_item(input logic mode, input logic [TW-1:0] test, input logic hold);
      sched_item_type item;
      item.mode      = mode;
      item.test_time = test;
      item.hold      = hold;
      pending_items.push_back(item);
   endtask

   // Waits until everything sent has been answered, then lets the block settle.
   task automatic drain_block();
      @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [TW-1:0] clamp_time(input longint t);
      if (t < 0)
         return '0;
      if (t > TIME_MAX)
         return TIME_MAX;
      return t[TW-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] noisy_upper(input logic [PERIOD_W-1:0] value);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      if ($urandom_range(3) != 0)
         noise = '0;
      return {noise[CSR_DATA_W-PERIOD_W-1:0], value};
   endfunction

   // Draws a new timer setting that keeps most queries on the repeat schedule.
   task automatic apply_random_settings();
      logic [1:0]  kind;
      logic [63:0] life_begin;
      logic [63:0] life_end;
      logic [63:0] delay;
      logic [63:0] period;
      logic [63:0] limit;
      logic [63:0] first;
      logic [63:0] step;
      logic [63:0] noise;
      kind = KIND_TIMER_START;
      if ($urandom_range(9) >= 8)
         kind = $urandom_range(3);
      case ($urandom_range(3))
         0: life_begin = 0;
         1: life_begin = $urandom_range(1000);
         2: life_begin = {$urandom, $urandom} & TIME_MAX;
         default: life_begin = TIME_MAX - $urandom_range(1000);
      endcase
      case ($urandom_range(3))
         0: delay = 0;
         1: delay = $urandom_range(100);
         2: delay = $urandom & PERIOD_MAX;
         default: delay = PERIOD_MAX;
      endcase
      case ($urandom_range(5))
         0: period = 0;
         1: period = 1;
         2, 3: period = $urandom_range(200, 2);
         4: period = $urandom & PERIOD_MAX;
         default: period = PERIOD_MAX;
      endcase
      case ($urandom_range(4))
         0, 1: limit = 0;
         2: limit = $urandom_range(20, 1);
         3: limit = $urandom & PERIOD_MAX;
         default: limit = PERIOD_MAX;
      endcase
      first = time_sat_add(life_begin, delay);
      step  = (period == 0) ? 64'd1 : period;
      case ($urandom_range(5))
         0, 1: life_end = TIME_MAX;
         2, 3: life_end = time_sat_add(first, $urandom_range(40) * step + $urandom_range(3));
         4: life_end = {$urandom, $urandom} & TIME_MAX;
         default: life_end = clamp_time(longint'(first) - $urandom_range(5));
      endcase
      noise = {$urandom, $urandom};
      if ($urandom_range(1) == 0)
         noise = '0;
      apply_settings({noise[CSR_DATA_W-3:0], kind}, life_begin, life_end,
                     noisy_upper(delay), noisy_upper(period), noisy_upper(limit));
   endtask

   // Picks a test time around the first run, the repeat points or the life end.
   function automatic logic [TW-1:0] pick_test_time();
      longint first;
      longint step;
      longint k;
      longint offset;
      longint t;
      first = time_sat_add(cfg_life_begin, cfg_first_delay);
      step  = (cfg_repeat_period == 0) ? 1 : cfg_repeat_period;
      if (cfg_run_limit != 0 && cfg_run_limit <= 20)
         k = $urandom_range(cfg_run_limit + 2);
      else
         k = $urandom_range(30);
      case ($urandom_range(2))
         0: offset = 0;
         1: offset = step - 1;
         default: offset = $urandom % step;
      endcase
      case ($urandom_range(9))
         0: t = {$urandom, $urandom} & TIME_MAX;
         1: t = first - $urandom_range(3);
         2: t = first + $urandom_range(3);
         3, 4, 5: t = first + k * step + offset;
         6: t = longint'(cfg_life_end) - 1 + $urandom_range(2);
         7: t = ($urandom_range(1) == 0) ? 0 : TIME_MAX;
         default: t = first + ($urandom % 1000000);
      endcase
      return clamp_time(t);
   endfunction

   // Stimulus: directed corner cases, then random phases under changing settings.
   initial begin : stimulus
      int phase;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Settings left at reset: no repeat, query at the end of time is overdue.
      queue_item(MODE_QUERY, '0, 1'b0);
      queue_item(MODE_QUERY, TIME_MAX, 1'b0);
      queue_item(MODE_FIRED, '0, 1'b0);
      drain_block();

      // Period of one sets the count just below its top; two fires saturate it.
      apply_settings(KIND_TIMER_START, 0, TIME_MAX, 0, 1, 0);
      queue_item(MODE_QUERY, TIME_MAX - 1'b1, 1'b0);
      queue_item(MODE_FIRED, TIME_MAX, 1'b0);
      queue_item(MODE_FIRED, '0, 1'b0);
      drain_block();

      // The saturated count meets the widest run limit.
      apply_settings(KIND_TIMER_START, 0, TIME_MAX, 0, 1, PERIOD_MAX);
      queue_item(MODE_FIRED, '0, 1'b0);
      drain_block();

      // First run saturates at the end of time and lies at the life end.
      apply_settings(KIND_TIMER_START, TIME_MAX, TIME_MAX, PERIOD_MAX, PERIOD_MAX, 0);
      queue_item(MODE_QUERY, 40'd5, 1'b0);
      queue_item(MODE_QUERY, TIME_MAX, 1'b0);
      drain_block();

      // Unserved start kinds; the life end check wins over the kind check.
      apply_settings(KIND_RESERVED, 0, 1000, 0, 0, 0);
      queue_item(MODE_QUERY, 40'd2000, 1'b0);
      queue_item(MODE_QUERY, 40'd10, 1'b0);
      drain_block();
      apply_settings(KIND_SYSTEM_BOOT, 0, 1000, 0, 0, 0);
      queue_item(MODE_QUERY, 40'd10, 1'b0);
      drain_block();
      apply_settings(KIND_APP_START, 0, 1000, 0, 0, 0);
      queue_item(MODE_QUERY, 40'd10, 1'b0);
      drain_block();

      // A small schedule: first run at 150, every 10 s, three runs allowed.
      apply_settings(KIND_TIMER_START, 100, 1000, 50, 10, 3);
      queue_item(MODE_QUERY, 40'd149, 1'b0);
      queue_item(MODE_QUERY, 40'd150, 1'b0);
      queue_item(MODE_QUERY, 40'd175, 1'b0);
      queue_item(MODE_QUERY, 40'd180, 1'b0);
      queue_item(MODE_FIRED, '0, 1'b0);
      queue_item(MODE_QUERY, 40'd999, 1'b0);
      drain_block();

      // Next repeat lands before and then at or past the life end.
      apply_settings(KIND_TIMER_START, 100, 185, 50, 10, 0);
      queue_item(MODE_QUERY, 40'd179, 1'b0);
      queue_item(MODE_QUERY, 40'd181, 1'b0);
      drain_block();

      // Widest period near the end of time: the next repeat saturates.
      apply_settings(KIND_TIMER_START, 0, TIME_MAX, 0, PERIOD_MAX, 0);
      queue_item(MODE_QUERY, TIME_MAX - 1'b1, 1'b0);
      drain_block();

      for (phase = 0; phase < PHASES; phase++) begin
         if (phase < PHASES / 3) begin
            sender_idle_pct   = 33;
            receiver_idle_pct = 73;
         end else if (phase < 2 * PHASES / 3) begin
            sender_idle_pct   = 73;
            receiver_idle_pct = 33;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         apply_random_settings();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 30)
               queue_item(MODE_FIRED, {$urandom, $urandom}, $urandom_range(49) == 0);
            else
               queue_item(MODE_QUERY, pick_test_time(), $urandom_range(49) == 0);
         end
         drain_block();
      end

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
